/* sv/per_queue_metric_table_unit_assert.svh */
// ----------------------------------------------------------------------------
// Per-queue metric table assertion macros
// Clocked implication checks used by the assertions of the top-level module.
// ----------------------------------------------------------------------------
`ifndef PER_QUEUE_METRIC_TABLE_UNIT_ASSERT_SVH
`define PER_QUEUE_METRIC_TABLE_UNIT_ASSERT_SVH
// Asserts that a condition implies a consequence on the same edge.
`define PQM_ASSERT_IMP(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error(msg);
// Asserts that a condition implies a consequence on the next edge.
`define PQM_ASSERT_NEXT(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);
`endif

/* sv/pqm_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Per-queue metric table package
// Shared widths, request and status codes, and the queued command type.
// ----------------------------------------------------------------------------
package pqm_pkg;
	localparam int QUEUE_COUNT = 16;
	localparam int QW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
	localparam int SUM_WIDTH = 48;
	localparam int CW = 32;

	localparam logic [1:0] REQ_UPDATE = 2'd0;
	localparam logic [1:0] REQ_ADD    = 2'd1;
	localparam logic [1:0] REQ_REMOVE = 2'd2;
	localparam logic [1:0] REQ_REPORT = 2'd3;

	localparam logic [2:0] ST_ADD_OK      = 3'd0;
	localparam logic [2:0] ST_ADD_EXISTS  = 3'd1;
	localparam logic [2:0] ST_REM_OK      = 3'd2;
	localparam logic [2:0] ST_REM_MISSING = 3'd3;
	localparam logic [2:0] ST_REPORT      = 3'd4;
	localparam logic [2:0] ST_EMPTY       = 3'd5;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [3:0]  queue_id;
		logic [31:0] max_size;
		logic [31:0] current_depth;
		logic [31:0] discard_count;
		logic [31:0] delay_us;
	} cmd_t;

	typedef struct packed {
		logic fifo_full;
		logic back_idle;
	} ctl_t;
endpackage
`default_nettype wire

/* sv/pqm_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Per-queue metric table front end
// Accepts commands into a two-entry queue that feeds the back end.
// ----------------------------------------------------------------------------
module pqm_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire pqm_pkg::cmd_t push_cmd,
	input  wire logic          pop,
	output pqm_pkg::cmd_t      head,
	output logic               nonempty,
	output logic               full
);
	pqm_pkg::cmd_t mem_q [2];
	logic          wp_q, rp_q;
	logic [1:0]    cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_cmd;
	end

	assign head = mem_q[rp_q];
	assign nonempty = (cnt_q != 2'd0);
	assign full = (cnt_q == 2'd2);
endmodule
`default_nettype wire

/* sv/pqm_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Per-queue metric table divider
// Restoring divider, one quotient bit per cycle, saturating to 32 bits.
// ----------------------------------------------------------------------------
module pqm_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         go,
	input  wire logic [pqm_pkg::SUM_WIDTH-1:0] dividend,
	input  wire logic [31:0]                  divisor,
	output logic                              done,
	output logic [31:0]                       quotient
);
	localparam int SW = pqm_pkg::SUM_WIDTH;
	localparam int BW = $clog2(SW + 1);

	logic [SW-1:0] quo_q;
	logic [32:0]   rem_q;
	logic [31:0]   dsr_q;
	logic [BW-1:0] cnt_q;
	logic          run_q;
	logic [32:0]   trial;
	logic [32:0]   diff;

	assign trial = {rem_q[31:0], quo_q[SW-1]};
	assign diff = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= BW'(SW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == BW'(1)) begin
					run_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (run_q) begin
			if (!diff[32]) begin
				rem_q <= diff;
				quo_q <= {quo_q[SW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[SW-2:0], 1'b0};
			end
		end
	end

	assign quotient = (|quo_q[SW-1:32]) ? 32'hFFFF_FFFF : quo_q[31:0];
endmodule
`default_nettype wire

/* sv/pqm_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Per-queue metric table back end
// Executes commands against the table and walks the table for reports.
// ----------------------------------------------------------------------------
module pqm_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          avail,
	input  wire pqm_pkg::cmd_t cmd,
	output logic               pop,
	output logic               idle,
	output logic               strobe,
	output logic [2:0]         status,
	output logic [3:0]         out_queue_id,
	output logic [31:0]        out_max_size,
	output logic [31:0]        depth_high_water,
	output logic [31:0]        discard_high_water,
	output logic [31:0]        avg_delay_us,
	output logic               last
);
	localparam int N  = pqm_pkg::QUEUE_COUNT;
	localparam int QW = pqm_pkg::QW;
	localparam int SW = pqm_pkg::SUM_WIDTH;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_DIV  = 2'd2;

	logic [N-1:0]    valid_q;
	logic [31:0]     mx_q  [N];
	logic [31:0]     dp_q  [N];
	logic [31:0]     dc_q  [N];
	logic [31:0]     cnt_q [N];
	logic [SW-1:0]   sum_q [N];
	logic [1:0]      state_q;
	logic [QW-1:0]   idx_q;
	logic            any_q;
	logic            div_go;
	logic            div_done;
	logic [31:0]     quo;

	logic            in_rng;
	logic [QW-1:0]   q;
	logic            ent_ok;
	logic [31:0]     u_cnt, u_mx, u_dp, u_dc;
	logic [SW-1:0]   u_sum;
	logic [SW:0]     sum_add;
	logic [N-1:0]    rest;
	logic            more;

	assign in_rng = ({28'd0, cmd.queue_id} < 32'(N));
	assign q = QW'(cmd.queue_id);
	assign ent_ok = in_rng && valid_q[q];
	assign sum_add = {1'b0, (ent_ok ? sum_q[q] : {SW{1'b0}})} + (SW+1)'(cmd.delay_us);

	always_comb begin
		u_cnt = ent_ok ? cnt_q[q] : 32'd0;
		u_mx  = ent_ok ? mx_q[q] : 32'd0;
		u_dp  = ent_ok ? dp_q[q] : 32'd0;
		u_dc  = ent_ok ? dc_q[q] : 32'd0;
		if (u_cnt != 32'hFFFF_FFFF) u_cnt = u_cnt + 32'd1;
		u_sum = sum_add[SW] ? {SW{1'b1}} : sum_add[SW-1:0];
		if (u_mx != cmd.max_size) u_dp = 32'd0;
		if (u_dp < cmd.current_depth) u_dp = cmd.current_depth;
		if (u_dc < cmd.discard_count) u_dc = cmd.discard_count;
	end

	// Entries above the current scan index that are still valid.
	always_comb begin
		for (int i = 0; i < N; i++) rest[i] = valid_q[i] && (i > int'(idx_q));
		more = |rest;
	end

	assign pop = (state_q == S_IDLE) && avail;
	assign div_go = (state_q == S_SCAN) && valid_q[idx_q] && (cnt_q[idx_q] != 32'd0);
	assign idle = (state_q == S_IDLE);

	pqm_div u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go), .dividend(sum_q[idx_q]),
		.divisor(cnt_q[idx_q]), .done(div_done), .quotient(quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			state_q <= S_IDLE;
			idx_q <= '0;
			any_q <= 1'b0;
			strobe <= 1'b0;
		end else begin
			strobe <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (avail) begin
						case (cmd.req_type)
							pqm_pkg::REQ_UPDATE: if (in_rng) valid_q[q] <= 1'b1;
							pqm_pkg::REQ_ADD: begin
								strobe <= 1'b1;
								if (in_rng && !valid_q[q]) valid_q[q] <= 1'b1;
							end
							pqm_pkg::REQ_REMOVE: begin
								strobe <= 1'b1;
								if (ent_ok) valid_q[q] <= 1'b0;
							end
							default: begin
								state_q <= S_SCAN;
								idx_q <= '0;
								any_q <= 1'b0;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (!valid_q[idx_q]) begin
						if (idx_q == QW'(N - 1)) begin
							state_q <= S_IDLE;
							if (!any_q) strobe <= 1'b1;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end else if (cnt_q[idx_q] == 32'd0) begin
						strobe <= 1'b1;
						any_q <= 1'b1;
						if (!more) state_q <= S_IDLE;
						else idx_q <= idx_q + 1'b1;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						strobe <= 1'b1;
						any_q <= 1'b1;
						if (!more) state_q <= S_IDLE;
						else begin
							state_q <= S_SCAN;
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && avail) begin
			status <= pqm_pkg::ST_ADD_EXISTS;
			out_queue_id <= cmd.queue_id;
			out_max_size <= '0;
			depth_high_water <= '0;
			discard_high_water <= '0;
			avg_delay_us <= '0;
			last <= 1'b1;
			case (cmd.req_type)
				pqm_pkg::REQ_UPDATE: begin
					if (in_rng) begin
						cnt_q[q] <= u_cnt;
						sum_q[q] <= u_sum;
						mx_q[q] <= cmd.max_size;
						dp_q[q] <= u_dp;
						dc_q[q] <= u_dc;
					end
				end
				pqm_pkg::REQ_ADD: begin
					if (in_rng && !valid_q[q]) begin
						status <= pqm_pkg::ST_ADD_OK;
						mx_q[q] <= cmd.max_size;
						dp_q[q] <= '0;
						dc_q[q] <= '0;
						cnt_q[q] <= '0;
						sum_q[q] <= '0;
					end
				end
				pqm_pkg::REQ_REMOVE:
					status <= ent_ok ? pqm_pkg::ST_REM_OK : pqm_pkg::ST_REM_MISSING;
				default: ;
			endcase
		end else if (state_q == S_SCAN && !valid_q[idx_q]) begin
			status <= pqm_pkg::ST_EMPTY;
			out_queue_id <= '0;
			out_max_size <= '0;
			depth_high_water <= '0;
			discard_high_water <= '0;
			avg_delay_us <= '0;
			last <= 1'b1;
		end else if ((state_q == S_SCAN && cnt_q[idx_q] == 32'd0) ||
				(state_q == S_DIV && div_done)) begin
			status <= pqm_pkg::ST_REPORT;
			out_queue_id <= 4'(idx_q);
			out_max_size <= mx_q[idx_q];
			depth_high_water <= dp_q[idx_q];
			discard_high_water <= dc_q[idx_q];
			avg_delay_us <= (state_q == S_DIV) ? quo : 32'd0;
			last <= !more;
			dp_q[idx_q] <= '0;
			dc_q[idx_q] <= '0;
			cnt_q[idx_q] <= '0;
			sum_q[idx_q] <= '0;
		end
	end
endmodule
`default_nettype wire

/* sv/per_queue_metric_table_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Per-queue metric table
// Statistics table indexed by queue number with add, remove and report.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Requests enter a
// two-entry queue; the back end executes one at a time from it.
// Update gives no result. Add and remove give one result, with strobe high:
// the command is registered in the queue, then the back end executes it and
// registers the result. Report walks the entries, one per cycle while the
// divider is idle, and each valid entry with samples passes through the
// bit-serial divider that forms the average; its records come out in
// ascending queue order, the final one with last set. Sustained update rate
// is one per cycle: the back end retires one queued command per cycle while
// it is not walking a report. Reset empties the queue and invalidates every
// entry. Results are shown for one cycle; the receiver cannot stall them.
// ----------------------------------------------------------------------------
`include "per_queue_metric_table_unit_assert.svh"
module per_queue_metric_table_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  req_type,
	input  wire logic [3:0]  queue_id,
	input  wire logic [31:0] max_size,
	input  wire logic [31:0] current_depth,
	input  wire logic [31:0] discard_count,
	input  wire logic [31:0] delay_us,
	output logic             strobe,
	output logic [2:0]       status,
	output logic [3:0]       out_queue_id,
	output logic [31:0]      out_max_size,
	output logic [31:0]      depth_high_water,
	output logic [31:0]      discard_high_water,
	output logic [31:0]      avg_delay_us,
	output logic             last
);
	pqm_pkg::cmd_t in_cmd, head;
	pqm_pkg::ctl_t ctl;
	logic          push, pop, nonempty;

	assign in_cmd = '{req_type, queue_id, max_size, current_depth, discard_count, delay_us};
	assign busy = ctl.fifo_full;
	assign push = start && !busy;

	pqm_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .push_cmd(in_cmd), .pop(pop),
		.head(head), .nonempty(nonempty), .full(ctl.fifo_full)
	);

	pqm_back u_back (
		.clk(clk), .arst_n(arst_n), .avail(nonempty), .cmd(head), .pop(pop),
		.idle(ctl.back_idle), .strobe(strobe), .status(status),
		.out_queue_id(out_queue_id), .out_max_size(out_max_size),
		.depth_high_water(depth_high_water), .discard_high_water(discard_high_water),
		.avg_delay_us(avg_delay_us), .last(last)
	);

	`PQM_ASSERT_IMP(a_pop_needs_data, pop, nonempty, "pop from empty queue")
	`PQM_ASSERT_IMP(a_pop_idle, pop, ctl.back_idle, "pop while back end busy")
	`PQM_ASSERT_IMP(a_status_range, strobe, status <= pqm_pkg::ST_EMPTY, "bad status code")
	`PQM_ASSERT_NEXT(a_add_result, pop && head.req_type == pqm_pkg::REQ_ADD,
		strobe && last, "add without single result")
endmodule
`default_nettype wire

/* tb/per_queue_metric_table_unit_test.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Per-queue metric table testbench
// Drives update, add, remove and report requests with random gaps, predicts
// every result from a private copy of the statistics table and checks each
// strobed result, field by field, in order of arrival.
// ----------------------------------------------------------------------------
module per_queue_metric_table_unit_test;
	typedef struct {
		logic [2:0]  status;
		logic [3:0]  qid;
		logic [31:0] max_size;
		logic [31:0] depth_hw;
		logic [31:0] discard_hw;
		logic [31:0] avg_delay;
		logic        last;
	} stat_rec_t;

	class stats_scoreboard;
		bit              valid[pqm_pkg::QUEUE_COUNT];
		logic [31:0]     max_sz[pqm_pkg::QUEUE_COUNT];
		logic [31:0]     depth_pk[pqm_pkg::QUEUE_COUNT];
		logic [31:0]     disc_pk[pqm_pkg::QUEUE_COUNT];
		logic [31:0]     samples[pqm_pkg::QUEUE_COUNT];
		logic [pqm_pkg::SUM_WIDTH-1:0] dsum[pqm_pkg::QUEUE_COUNT];
		stat_rec_t       pending_recs[$];
		int              errors;
		int              checked;
		int              reports;
		int              updates;

		function void clear_entry(int q, logic [31:0] mx);
			valid[q] = 1;
			max_sz[q] = mx;
			depth_pk[q] = '0;
			disc_pk[q] = '0;
			samples[q] = '0;
			dsum[q] = '0;
		endfunction

		function void push_rec(logic [2:0] st, logic [3:0] q, logic [31:0] mx,
				logic [31:0] dp, logic [31:0] dc, logic [31:0] av, logic lst);
			stat_rec_t r;
			r.status = st; r.qid = q; r.max_size = mx; r.depth_hw = dp;
			r.discard_hw = dc; r.avg_delay = av; r.last = lst;
			pending_recs = {pending_recs, r};
		endfunction

		function void note_request(logic [1:0] kind, logic [3:0] q, logic [31:0] mx,
				logic [31:0] depth, logic [31:0] disc, logic [31:0] delay);
			logic [pqm_pkg::SUM_WIDTH:0] wide_sum;
			logic [63:0]        quot;
			int                 n;
			n = 0;
			case (kind)
				pqm_pkg::REQ_UPDATE: begin
					updates++;
					if (!valid[q])
						clear_entry(q, '0);
					if (samples[q] != 32'hFFFF_FFFF)
						samples[q] = samples[q] + 32'd1;
					wide_sum = {1'b0, dsum[q]} + (pqm_pkg::SUM_WIDTH+1)'(delay);
					dsum[q] = wide_sum[pqm_pkg::SUM_WIDTH] ? {pqm_pkg::SUM_WIDTH{1'b1}} :
						wide_sum[pqm_pkg::SUM_WIDTH-1:0];
					if (max_sz[q] != mx) begin
						max_sz[q] = mx;
						depth_pk[q] = '0;
					end
					if (depth_pk[q] < depth)
						depth_pk[q] = depth;
					if (disc_pk[q] < disc)
						disc_pk[q] = disc;
				end
				pqm_pkg::REQ_ADD: begin
					if (!valid[q]) begin
						clear_entry(q, mx);
						push_rec(pqm_pkg::ST_ADD_OK, q, '0, '0, '0, '0, 1'b1);
					end else
						push_rec(pqm_pkg::ST_ADD_EXISTS, q, '0, '0, '0, '0, 1'b1);
				end
				pqm_pkg::REQ_REMOVE: begin
					if (valid[q]) begin
						valid[q] = 0;
						push_rec(pqm_pkg::ST_REM_OK, q, '0, '0, '0, '0, 1'b1);
					end else
						push_rec(pqm_pkg::ST_REM_MISSING, q, '0, '0, '0, '0, 1'b1);
				end
				default: begin
					reports++;
					for (int i = 0; i < pqm_pkg::QUEUE_COUNT; i++) begin
						if (!valid[i])
							continue;
						quot = (samples[i] == 32'd0) ? 64'd0 :
							64'(dsum[i]) / 64'(samples[i]);
						push_rec(pqm_pkg::ST_REPORT, 4'(i), max_sz[i], depth_pk[i],
							disc_pk[i],
							(quot > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quot[31:0], 1'b0);
						n++;
						depth_pk[i] = '0;
						disc_pk[i] = '0;
						samples[i] = '0;
						dsum[i] = '0;
					end
					if (n == 0)
						push_rec(pqm_pkg::ST_EMPTY, '0, '0, '0, '0, '0, 1'b1);
					else
						pending_recs[pending_recs.size()-1].last = 1'b1;
				end
			endcase
		endfunction

		function void check_result(stat_rec_t got);
			stat_rec_t want;
			if (pending_recs.size() == 0) begin
				$display("%0t: result with no expectation, status %0d queue %0d",
					$time, got.status, got.qid);
				errors++;
				return;
			end
			want = pending_recs.pop_front();
			checked++;
			if (got.status !== want.status) begin
				$display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
				errors++;
			end
			if (got.qid !== want.qid) begin
				$display("%0t: queue id expected %0d actual %0d", $time, want.qid, got.qid);
				errors++;
			end
			if (got.max_size !== want.max_size) begin
				$display("%0t: max size expected %h actual %h", $time, want.max_size,
					got.max_size);
				errors++;
			end
			if (got.depth_hw !== want.depth_hw) begin
				$display("%0t: depth high water expected %h actual %h", $time, want.depth_hw,
					got.depth_hw);
				errors++;
			end
			if (got.discard_hw !== want.discard_hw) begin
				$display("%0t: discard high water expected %h actual %h", $time,
					want.discard_hw, got.discard_hw);
				errors++;
			end
			if (got.avg_delay !== want.avg_delay) begin
				$display("%0t: average delay expected %h actual %h", $time, want.avg_delay,
					got.avg_delay);
				errors++;
			end
			if (got.last !== want.last) begin
				$display("%0t: last expected %b actual %b", $time, want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	localparam int STALL_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  req_type;
	logic [3:0]  queue_id;
	logic [31:0] max_size;
	logic [31:0] current_depth;
	logic [31:0] discard_count;
	logic [31:0] delay_us;
	logic        strobe;
	logic [2:0]  status;
	logic [3:0]  out_queue_id;
	logic [31:0] out_max_size;
	logic [31:0] depth_high_water;
	logic [31:0] discard_high_water;
	logic [31:0] avg_delay_us;
	logic        last;

	stats_scoreboard sb;
	int              stall_cycles;
	bit              no_gaps;

	per_queue_metric_table_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .queue_id(queue_id), .max_size(max_size),
		.current_depth(current_depth), .discard_count(discard_count), .delay_us(delay_us),
		.strobe(strobe), .status(status), .out_queue_id(out_queue_id),
		.out_max_size(out_max_size), .depth_high_water(depth_high_water),
		.discard_high_water(discard_high_water), .avg_delay_us(avg_delay_us), .last(last)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		stat_rec_t got;
		if (arst_n) begin
			if (strobe) begin
				got.status = status; got.qid = out_queue_id; got.max_size = out_max_size;
				got.depth_hw = depth_high_water; got.discard_hw = discard_high_water;
				got.avg_delay = avg_delay_us; got.last = last;
				sb.check_result(got);
			end
			if (start && !busy)
				sb.note_request(req_type, queue_id, max_size, current_depth,
					discard_count, delay_us);
			if (strobe || (start && !busy))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	task automatic idle_cycles(int n);
		for (int i = 0; i < n; i++) begin
			@(negedge clk);
			start = 1'b0;
		end
	endtask

	task automatic random_gap();
		if (no_gaps)
			return;
		if ($urandom_range(0, 9) < 8)
			idle_cycles($urandom_range(0, 2));
		else
			idle_cycles($urandom_range(10, 40));
	endtask

	// Holds the request on the ports until a transaction takes it.
	task automatic send_request(logic [1:0] kind, logic [3:0] q, logic [31:0] mx,
			logic [31:0] depth, logic [31:0] disc, logic [31:0] delay);
		@(negedge clk);
		start = 1'b1;
		req_type = kind; queue_id = q; max_size = mx;
		current_depth = depth; discard_count = disc; delay_us = delay;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Drops start first so that the last request is not taken again.
	task automatic wait_drained();
		@(negedge clk);
		start = 1'b0;
		while (sb.pending_recs.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 5))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom_range(0, 100);
			default: return $urandom;
		endcase
	endfunction

	initial begin
		logic [1:0]  kind;
		logic [3:0]  q;
		int          sel;
		sb = new();
		stall_cycles = 0;
		no_gaps = 0;
		arst_n = 1'b0;
		start = 1'b0;
		req_type = pqm_pkg::REQ_UPDATE; queue_id = '0; max_size = '0;
		current_depth = '0; discard_count = '0; delay_us = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty report, add and remove outcomes, implicit creation,
		// max-size change, field extremes and a report of cleared counters.
		send_request(pqm_pkg::REQ_REPORT, 4'd0, '0, '0, '0, '0);
		send_request(pqm_pkg::REQ_ADD, 4'd0, 32'h0, '0, '0, '0);
		send_request(pqm_pkg::REQ_ADD, 4'd15, 32'hFFFF_FFFF, '0, '0, '0);
		send_request(pqm_pkg::REQ_ADD, 4'd0, 32'h1234, '0, '0, '0);
		send_request(pqm_pkg::REQ_UPDATE, 4'd0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF);
		send_request(pqm_pkg::REQ_UPDATE, 4'd0, 32'h0, 32'h5, 32'h0, 32'h0);
		send_request(pqm_pkg::REQ_UPDATE, 4'd5, 32'h0, 32'h10, 32'h20, 32'd7);
		send_request(pqm_pkg::REQ_UPDATE, 4'd15, 32'hFFFF_FFFF, 32'd100, 32'd3, 32'd9);
		send_request(pqm_pkg::REQ_UPDATE, 4'd15, 32'd77, 32'd40, 32'd1, 32'd2);
		send_request(pqm_pkg::REQ_REPORT, 4'd9, '0, '0, '0, '0);
		send_request(pqm_pkg::REQ_REPORT, 4'd0, '0, '0, '0, '0);
		send_request(pqm_pkg::REQ_REMOVE, 4'd5, '0, '0, '0, '0);
		send_request(pqm_pkg::REQ_REMOVE, 4'd5, '0, '0, '0, '0);
		send_request(pqm_pkg::REQ_UPDATE, 4'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0,
			32'hFFFF_FFFF);
		send_request(pqm_pkg::REQ_UPDATE, 4'd3, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF,
			32'hFFFF_FFFE);
		send_request(pqm_pkg::REQ_REPORT, 4'd0, '0, '0, '0, '0);
		send_request(pqm_pkg::REQ_REMOVE, 4'd0, '0, '0, '0, '0);
		send_request(pqm_pkg::REQ_REMOVE, 4'd3, '0, '0, '0, '0);
		send_request(pqm_pkg::REQ_REMOVE, 4'd15, '0, '0, '0, '0);
		send_request(pqm_pkg::REQ_REPORT, 4'd0, '0, '0, '0, '0);

		// Pause the sender until the table has answered everything.
		wait_drained();

		for (int n = 0; n < 80; n++) begin
			if (n % 20 == 0)
				no_gaps = ($urandom_range(0, 1) == 1);
			sel = $urandom_range(0, 99);
			kind = (sel < 60) ? pqm_pkg::REQ_UPDATE : (sel < 75) ? pqm_pkg::REQ_ADD :
				(sel < 88) ? pqm_pkg::REQ_REMOVE : pqm_pkg::REQ_REPORT;
			// A few hot queues keep most requests hitting existing entries.
			q = ($urandom_range(0, 3) != 0) ? 4'($urandom_range(0, 3)) : 4'($urandom);
			if (kind == pqm_pkg::REQ_UPDATE && $urandom_range(0, 2) != 0)
				send_request(kind, q, sb.valid[q] ? sb.max_sz[q] : 32'h0, pick_word(),
					pick_word(), pick_word());
			else
				send_request(kind, q, pick_word(), pick_word(), pick_word(), pick_word());
			random_gap();
			if (n == 40)
				wait_drained();
		end
		send_request(pqm_pkg::REQ_REPORT, 4'd0, '0, '0, '0, '0);
		@(negedge clk);
		start = 1'b0;

		wait_drained();
		repeat (200) @(posedge clk);
		$display("Checked %0d results from %0d updates and %0d reports.", sb.checked,
			sb.updates, sb.reports);
		if (sb.pending_recs.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time,
				sb.pending_recs.size());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
`default_nettype wire

/* files.f */
+incdir+sv
sv/pqm_pkg.sv
sv/pqm_front.sv
sv/pqm_div.sv
sv/pqm_back.sv
sv/per_queue_metric_table_unit.sv
tb/per_queue_metric_table_unit_test.sv
